[rtl/modpow_pkg.sv]
package modpow_pkg;

	localparam int BASE_W       = 63;
	localparam int EXP_FIELD_W  = 31;
	localparam int MOD_FIELD_W  = 31;
	localparam int RES_W        = 31;
	localparam int EXP_W_DEF    = 31;
	localparam int MOD_W_DEF    = 31;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BASE,
		ST_BIT,
		ST_MUL_ACC,
		ST_RED_ACC,
		ST_MUL_SQ,
		ST_RED_SQ,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic mul_acc;
		logic mul_sq;
		logic red_step;
		logic to_base;
		logic to_acc;
		logic shift_e;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic red_done;
		logic e_zero;
		logic e_lsb;
		logic e_next_zero;
	} dp_status_t;

endpackage

[rtl/modpow_datapath.sv]
module modpow_datapath
	import modpow_pkg::*;
#(
	parameter int EXPONENT_WIDTH = EXP_W_DEF,
	parameter int MODULUS_WIDTH  = MOD_W_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [MOD_FIELD_W-1:0] cfg_wr_data,
	input  logic [BASE_W-1:0]      base_value,
	input  logic [EXP_FIELD_W-1:0] exponent_value,
	input  dp_cmd_t                cmd,
	output dp_status_t             status,
	output logic [RES_W-1:0]       power_result
);

	localparam int MW         = MODULUS_WIDTH;
	localparam int EW         = EXPONENT_WIDTH;
	localparam int PROD_W     = 2 * MW;
	localparam int DIV_W      = (PROD_W > BASE_W) ? PROD_W : BASE_W;
	localparam int BASE_SHIFT = DIV_W - BASE_W;
	localparam int PROD_SHIFT = DIV_W - PROD_W;
	localparam int CNT_W      = $clog2(DIV_W + 1);

	logic [MW-1:0]     mod_q;
	logic [MW-1:0]     mod_eff;
	logic [MW-1:0]     acc_q;
	logic [MW-1:0]     b_q;
	logic [EW-1:0]     e_q;
	logic [DIV_W-1:0]  sh_q;
	logic [MW-1:0]     rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [RES_W-1:0]  result_q;
	logic [MW-1:0]     mul_a;
	logic [PROD_W-1:0] product;
	logic [MW:0]       cand;
	logic [MW:0]       cand_sub;
	logic [MW-1:0]     rem_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_q <= MW'(1);
		end else if (cfg_wr_en) begin
			mod_q <= MW'(cfg_wr_data);
		end
	end

	assign mod_eff  = (mod_q == '0) ? MW'(1) : mod_q;
	assign mul_a    = cmd.mul_acc ? acc_q : b_q;
	assign product  = PROD_W'(mul_a) * PROD_W'(b_q);
	assign cand     = {rem_q, sh_q[DIV_W-1]};
	assign cand_sub = cand - {1'b0, mod_eff};
	assign rem_next = (cand >= {1'b0, mod_eff}) ? cand_sub[MW-1:0] : cand[MW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sh_q  <= DIV_W'(base_value) << BASE_SHIFT;
			rem_q <= '0;
			cnt_q <= CNT_W'(BASE_W);
			e_q   <= EW'(exponent_value);
			acc_q <= MW'(1);
		end else if (cmd.mul_acc || cmd.mul_sq) begin
			sh_q  <= DIV_W'(product) << PROD_SHIFT;
			rem_q <= '0;
			cnt_q <= CNT_W'(PROD_W);
		end else if (cmd.red_step) begin
			sh_q  <= sh_q << 1;
			rem_q <= rem_next;
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (cmd.to_base) begin
			b_q <= rem_q;
		end
		if (cmd.to_acc) begin
			acc_q <= rem_q;
		end
		if (cmd.shift_e) begin
			e_q <= e_q >> 1;
		end
		if (cmd.out_load) begin
			result_q <= RES_W'(acc_q);
		end
	end

	assign status.red_done    = (cnt_q == '0);
	assign status.e_zero      = (e_q == '0);
	assign status.e_lsb       = e_q[0];
	assign status.e_next_zero = ((e_q >> 1) == '0);
	assign power_result       = result_q;

endmodule

[rtl/modpow_ctrl.sv]
module modpow_ctrl
	import modpow_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_BASE;
			end
			ST_BASE: begin
				if (status.red_done) state_next = ST_BIT;
			end
			ST_BIT: begin
				priority if (status.e_zero) state_next = ST_FIN;
				else if (status.e_lsb) state_next = ST_MUL_ACC;
				else state_next = ST_MUL_SQ;
			end
			ST_MUL_ACC: state_next = ST_RED_ACC;
			ST_RED_ACC: begin
				if (status.red_done) begin
					state_next = status.e_next_zero ? ST_BIT : ST_MUL_SQ;
				end
			end
			ST_MUL_SQ: state_next = ST_RED_SQ;
			ST_RED_SQ: begin
				if (status.red_done) state_next = ST_BIT;
			end
			ST_FIN: begin
				if (out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.load = in_valid;
			ST_BASE: begin
				cmd.red_step = !status.red_done;
				cmd.to_base  = status.red_done;
			end
			ST_BIT: ;
			ST_MUL_ACC: cmd.mul_acc = 1'b1;
			ST_RED_ACC: begin
				cmd.red_step = !status.red_done;
				cmd.to_acc   = status.red_done;
				cmd.shift_e  = status.red_done && status.e_next_zero;
			end
			ST_MUL_SQ: cmd.mul_sq = 1'b1;
			ST_RED_SQ: begin
				cmd.red_step = !status.red_done;
				cmd.to_base  = status.red_done;
				cmd.shift_e  = status.red_done;
			end
			ST_FIN: cmd.out_load = out_free;
			default: ;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

[rtl/modular_power.sv]
// The base is first reduced modulo the modulus; then for each scanned exponent bit there is
// one decision state plus a multiply state and a bitwise reduction per modular product; the square
// after the top set bit is skipped, and a last decision state and an output load end the request.
// Only one request is in work at a time: in_stall stays high until the controller is back in
// idle, and the output load waits while a previous result is still held by out_stall.
// Reset (arst_n low) clears the controller, the output valid and sets the modulus to 1.
module modular_power
	import modpow_pkg::*;
#(
	parameter int EXPONENT_WIDTH = EXP_W_DEF,
	parameter int MODULUS_WIDTH  = MOD_W_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [MOD_FIELD_W-1:0] cfg_wr_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [BASE_W-1:0]      base_value,
	input  logic [EXP_FIELD_W-1:0] exponent_value,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [RES_W-1:0]       power_result
);

	dp_cmd_t    cmd;
	dp_status_t status;

	modpow_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	modpow_datapath #(
		.EXPONENT_WIDTH (EXPONENT_WIDTH),
		.MODULUS_WIDTH  (MODULUS_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.base_value     (base_value),
		.exponent_value (exponent_value),
		.cmd            (cmd),
		.status         (status),
		.power_result   (power_result)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after a request was taken");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a request in work");

	a_single_command: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.mul_acc, cmd.mul_sq, cmd.red_step}))
		else $error("conflicting datapath commands");

endmodule
